### design/kcg_pkg.sv
// ----------------------------------------------------------------------------
// kcg_pkg
// Shared types and constants for the k-combination generator.
// ----------------------------------------------------------------------------
package kcg_pkg;

	localparam int OFFSET_W           = 32;
	localparam int COUNT_W            = 4;
	localparam int COUNT_MAX          = (1 << COUNT_W) - 1;
	localparam int CFG_IDX_W          = 2;
	localparam int DEFAULT_MAX_CHOOSE = 8;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_LOW    = 2'd0,
		CFG_RANGE_HIGH   = 2'd1,
		CFG_CHOOSE_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT,
		ST_SCAN,
		ST_FILL
	} kcg_state_t;

	// commands from the sequencer to the offset store
	typedef struct packed {
		logic reinit;
		logic wr_en;
	} offset_cmd_t;

	// only entries below choose_count are ever touched, and choose_count
	// cannot exceed COUNT_MAX
	function automatic int store_depth(input int max_choose);
		return (max_choose < COUNT_MAX) ? max_choose : COUNT_MAX;
	endfunction

	function automatic int index_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

### design/kcg_offset_file.sv
// ----------------------------------------------------------------------------
// kcg_offset_file
// Offset store: one read port, one write port, and a reload that sets
// every entry to its own index at once.
// ----------------------------------------------------------------------------
module kcg_offset_file
	import kcg_pkg::*;
#(
	parameter int MAX_CHOOSE = DEFAULT_MAX_CHOOSE,
	localparam int DEPTH     = store_depth(MAX_CHOOSE),
	localparam int IDX_W     = index_width(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  offset_cmd_t         cmd,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [OFFSET_W-1:0] wr_data,
	input  logic [IDX_W-1:0]    rd_idx,
	output logic [OFFSET_W-1:0] rd_data
);

	logic [OFFSET_W-1:0] offs_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				offs_q[i] <= OFFSET_W'(i);
			end
		end else if (cmd.reinit) begin
			for (int i = 0; i < DEPTH; i++) begin
				offs_q[i] <= OFFSET_W'(i);
			end
		end else if (cmd.wr_en) begin
			offs_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = offs_q[rd_idx];

endmodule

### design/kcg_core.sv
// ----------------------------------------------------------------------------
// kcg_core
// Sequencer and shared compare/increment unit: emits the current
// combination one beat at a time, then scans and refills the offsets.
// ----------------------------------------------------------------------------
module kcg_core
	import kcg_pkg::*;
#(
	parameter int MAX_CHOOSE = DEFAULT_MAX_CHOOSE,
	localparam int DEPTH     = store_depth(MAX_CHOOSE),
	localparam int IDX_W     = index_width(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [OFFSET_W-1:0] range_low,
	input  logic [OFFSET_W-1:0] range_high,
	input  logic [COUNT_W-1:0]  choose_count,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OFFSET_W-1:0] element_value,
	output logic                last_element,
	output logic                exhausted,
	output offset_cmd_t         cmd,
	output logic [IDX_W-1:0]    idx,
	output logic [OFFSET_W-1:0] wr_data,
	input  logic [OFFSET_W-1:0] rd_data
);

	localparam int SIZE_W = OFFSET_W + 1;
	localparam int CEIL_W = OFFSET_W + 3;

	kcg_state_t          state_q, state_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [OFFSET_W-1:0] run_q, run_d;
	logic [CEIL_W-1:0]   nk_q, nk_d;
	logic                finished_q, finished_d;
	logic                out_valid_q;
	logic [OFFSET_W-1:0] value_q, value_d;
	logic                last_q, last_d;
	logic                exh_q, exh_d;
	logic                load;

	logic [SIZE_W-1:0]   span;
	logic [SIZE_W-1:0]   range_n;
	logic                count_bad;
	logic                too_many;
	logic                out_free;
	logic                at_last;
	logic [CEIL_W-1:0]   ceiling;
	logic                at_ceiling;
	logic [OFFSET_W-1:0] bumped;

	// range size, zero when the range is empty
	assign span    = {1'b0, range_high} - {1'b0, range_low};
	assign range_n = (range_high < range_low) ? '0 : span + SIZE_W'(1);

	assign count_bad = (choose_count == '0) ||
	                   ({1'b0, choose_count} > (COUNT_W+1)'(DEPTH));
	assign too_many  = SIZE_W'(choose_count) > range_n;
	assign out_free  = !out_valid_q || !out_stall;
	assign at_last   = COUNT_W'(idx_q) == (choose_count - COUNT_W'(1));

	// highest offset a position may hold: n - k + position
	assign ceiling    = nk_q + CEIL_W'(idx_q);
	assign at_ceiling = ceiling == CEIL_W'(rd_data);
	assign bumped     = (state_q == ST_FILL) ? run_q + OFFSET_W'(1)
	                                         : rd_data + OFFSET_W'(1);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		run_d      = run_q;
		nk_d       = nk_q;
		finished_d = finished_q;
		load       = 1'b0;
		value_d    = value_q;
		last_d     = last_q;
		exh_d      = exh_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					nk_d = CEIL_W'(range_n) - CEIL_W'(choose_count);
					if (restart) begin
						cmd.reinit = 1'b1;
						finished_d = count_bad || too_many;
					end
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				idx_d = '0;
				if (finished_q || count_bad) begin
					if (out_free) begin
						load    = 1'b1;
						value_d = '0;
						last_d  = 1'b1;
						exh_d   = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load    = 1'b1;
					value_d = range_low + rd_data;
					last_d  = at_last;
					exh_d   = 1'b0;
					if (at_last) begin
						state_d = ST_SCAN;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			ST_SCAN: begin
				if (at_ceiling) begin
					if (idx_q == '0) begin
						finished_d = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						idx_d = idx_q - IDX_W'(1);
					end
				end else begin
					cmd.wr_en = 1'b1;
					run_d     = bumped;
					if (at_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				// refill to the right with consecutive values
				cmd.wr_en = 1'b1;
				run_d     = bumped;
				if (at_last) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			finished_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			finished_q <= finished_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_q   <= run_d;
		nk_q    <= nk_d;
		value_q <= value_d;
		last_q  <= last_d;
		exh_q   <= exh_d;
	end

	assign idx           = idx_q;
	assign wr_data       = bumped;
	assign out_valid     = out_valid_q;
	assign element_value = value_q;
	assign last_element  = last_q;
	assign exhausted     = exh_q;

endmodule

### design/k_combination_generator.sv
// A request is checked, then its k beats are emitted one at a time
// (held while the output is stalled), then the offsets are scanned and
// refilled; an exhausted request gets a single exhausted beat.
// A new request is taken only once the previous one has finished its scan and
// refill; the single offset read port is shared by the emit and scan steps.
// Reset: offsets reload to their index, registers clear, block is finished.
// ----------------------------------------------------------------------------
// k_combination_generator
// Lexicographic k-combination generator over range_low..range_high.
// ----------------------------------------------------------------------------
module k_combination_generator
	import kcg_pkg::*;
#(
	parameter int MAX_CHOOSE = DEFAULT_MAX_CHOOSE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_en,
	input  logic [CFG_IDX_W-1:0] reg_index,
	input  logic [OFFSET_W-1:0]  write_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OFFSET_W-1:0]  element_value,
	output logic                 last_element,
	output logic                 exhausted
);

	localparam int DEPTH = store_depth(MAX_CHOOSE);
	localparam int IDX_W = index_width(DEPTH);

	logic [OFFSET_W-1:0] range_low_q;
	logic [OFFSET_W-1:0] range_high_q;
	logic [COUNT_W-1:0]  choose_count_q;

	offset_cmd_t         cmd;
	logic [IDX_W-1:0]    idx;
	logic [OFFSET_W-1:0] wr_data;
	logic [OFFSET_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q    <= '0;
			range_high_q   <= '0;
			choose_count_q <= '0;
		end else if (write_en) begin
			unique case (cfg_reg_t'(reg_index))
				CFG_RANGE_LOW:    range_low_q    <= write_data;
				CFG_RANGE_HIGH:   range_high_q   <= write_data;
				CFG_CHOOSE_COUNT: choose_count_q <= write_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	kcg_core #(
		.MAX_CHOOSE(MAX_CHOOSE)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.range_low    (range_low_q),
		.range_high   (range_high_q),
		.choose_count (choose_count_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.element_value(element_value),
		.last_element (last_element),
		.exhausted    (exhausted),
		.cmd          (cmd),
		.idx          (idx),
		.wr_data      (wr_data),
		.rd_data      (rd_data)
	);

	kcg_offset_file #(
		.MAX_CHOOSE(MAX_CHOOSE)
	) u_offsets (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.wr_idx (idx),
		.wr_data(wr_data),
		.rd_idx (idx),
		.rd_data(rd_data)
	);

endmodule

### sim/kcg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kcg_checker
// Watches the register port and both beat channels of the k-combination
// generator, keeps its own copy of the offsets and flags, predicts the beats
// of every accepted request and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module kcg_checker
	import kcg_pkg::*;
#(
	parameter int MAX_CHOOSE = DEFAULT_MAX_CHOOSE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_en,
	input  logic [CFG_IDX_W-1:0] reg_index,
	input  logic [OFFSET_W-1:0]  write_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 restart,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [OFFSET_W-1:0]  element_value,
	input  logic                 last_element,
	input  logic                 exhausted,
	output int                   failures,
	output int                   outstanding,
	output int                   beats_checked,
	output int                   exhaust_reports
);

	typedef struct packed {
		logic [OFFSET_W-1:0] value;
		logic                last;
		logic                exh;
	} combo_beat_t;

	combo_beat_t expected_beats[$];

	logic [OFFSET_W-1:0] range_low;
	logic [OFFSET_W-1:0] range_high;
	logic [COUNT_W-1:0]  choose_count;
	logic [OFFSET_W-1:0] offsets [MAX_CHOOSE];
	logic                finished;

	function automatic logic [63:0] span_size();
		if (range_high < range_low)
			return 64'd0;
		return {32'b0, range_high} - {32'b0, range_low} + 64'd1;
	endfunction

	task automatic rewind();
		for (int i = 0; i < MAX_CHOOSE; i++)
			offsets[i] = OFFSET_W'(i);
		finished = (choose_count == 0) || (choose_count > MAX_CHOOSE) ||
			(64'(choose_count) > span_size());
	endtask

	// rightmost offset still below its ceiling moves up, the rest follow it
	task automatic step_forward();
		logic [63:0] n;
		logic [63:0] k;
		int          i;
		n = span_size();
		k = 64'(choose_count);
		i = int'(choose_count) - 1;
		while (i >= 0 && {32'b0, offsets[i]} == n - k + 64'(i))
			i--;
		if (i < 0) begin
			finished = 1'b1;
			return;
		end
		offsets[i] = offsets[i] + 1'b1;
		for (int j = i + 1; j < int'(choose_count); j++)
			offsets[j] = offsets[j-1] + 1'b1;
	endtask

	task automatic predict_combination(input logic restart_bit);
		combo_beat_t beat;
		if (restart_bit)
			rewind();
		if (finished || choose_count == 0 || choose_count > MAX_CHOOSE) begin
			beat = '{value: '0, last: 1'b1, exh: 1'b1};
			expected_beats = {expected_beats, beat};
		end else begin
			for (int i = 0; i < int'(choose_count); i++) begin
				beat.value = range_low + offsets[i];
				beat.last  = (i == int'(choose_count) - 1);
				beat.exh   = 1'b0;
				expected_beats = {expected_beats, beat};
			end
			step_forward();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		combo_beat_t want;
		if (!arst_n) begin
			range_low       = '0;
			range_high      = '0;
			choose_count    = '0;
			rewind();
			expected_beats.delete();
			failures        = 0;
			beats_checked   = 0;
			exhaust_reports = 0;
			outstanding     <= 0;
		end else begin
			if (write_en) begin
				case (reg_index)
					CFG_RANGE_LOW:    range_low = write_data;
					CFG_RANGE_HIGH:   range_high = write_data;
					CFG_CHOOSE_COUNT: choose_count = write_data[COUNT_W-1:0];
					default:          ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_combination(restart);
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					failures++;
					$display("%0t: expected no beat, got value %h last %b exhausted %b",
						$time, element_value, last_element, exhausted);
				end else begin
					want = expected_beats.pop_front();
					beats_checked++;
					if (want.exh)
						exhaust_reports++;
					if (element_value !== want.value) begin
						failures++;
						$display("%0t: element_value expected %h, got %h",
							$time, want.value, element_value);
					end
					if (last_element !== want.last) begin
						failures++;
						$display("%0t: last_element expected %b, got %b",
							$time, want.last, last_element);
					end
					if (exhausted !== want.exh) begin
						failures++;
						$display("%0t: exhausted expected %b, got %b",
							$time, want.exh, exhausted);
					end
				end
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

### sim/k_combination_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_combination_generator_tb
// Drives register settings and combination requests into the generator with
// random gaps and output stalls, one long output hold-off, and lets the
// checker compare every result beat against its own prediction.
// ----------------------------------------------------------------------------
module k_combination_generator_tb;
	import kcg_pkg::*;

	localparam int MAX_CHOOSE      = DEFAULT_MAX_CHOOSE;
	localparam int RANDOM_REQUESTS = 280;
	localparam int SETTLE_CYCLES   = 2 * MAX_CHOOSE + 6;
	localparam int HOLD_CYCLES     = 200;
	localparam int CYCLE_LIMIT     = 200000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 write_en   = 1'b0;
	logic [CFG_IDX_W-1:0] reg_index  = CFG_RANGE_LOW;
	logic [OFFSET_W-1:0]  write_data = '0;
	logic                 in_valid   = 1'b0;
	logic                 restart    = 1'b0;
	logic                 out_stall  = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [OFFSET_W-1:0]  element_value;
	logic                 last_element;
	logic                 exhausted;

	int failures;
	int outstanding;
	int beats_checked;
	int exhaust_reports;
	int requests_sent  = 0;
	int settings_used  = 0;
	int cycles         = 0;
	bit idle_on        = 1'b1;
	logic hold_req     = 1'b0;

	k_combination_generator #(.MAX_CHOOSE(MAX_CHOOSE)) dut (
		.clk(clk), .arst_n(arst_n),
		.write_en(write_en), .reg_index(reg_index), .write_data(write_data),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.element_value(element_value), .last_element(last_element),
		.exhausted(exhausted)
	);

	kcg_checker #(.MAX_CHOOSE(MAX_CHOOSE)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.write_en(write_en), .reg_index(reg_index), .write_data(write_data),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.element_value(element_value), .last_element(last_element),
		.exhausted(exhausted),
		.failures(failures), .outstanding(outstanding),
		.beats_checked(beats_checked), .exhaust_reports(exhaust_reports)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles", $time, cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off when asked
	initial begin : receiver
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= idle_on && ($urandom_range(99) < 24);
		end
	end

	function automatic int n_choose(input int n, input int k);
		int r;
		if (k < 0 || k > n)
			return 0;
		r = 1;
		for (int i = 1; i <= k; i++)
			r = r * (n - k + i) / i;
		return r;
	endfunction

	task automatic send_request(input logic restart_bit);
		while (idle_on && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			restart  <= $urandom_range(1);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= restart_bit;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic send_burst(input int count, input bit first_restart, input bit noisy);
		for (int r = 0; r < count; r++)
			send_request(r == 0 ? first_restart : (noisy && $urandom_range(99) < 8));
	endtask

	// wait until every beat is back and the block has finished its advance
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [OFFSET_W-1:0] data);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= data;
		@(posedge clk);
	endtask

	task automatic cfg_close();
		write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [OFFSET_W-1:0] lo, input logic [OFFSET_W-1:0] hi,
			input logic [OFFSET_W-1:0] kword);
		drain();
		cfg_write(CFG_RANGE_LOW, lo);
		cfg_write(CFG_RANGE_HIGH, hi);
		cfg_write(CFG_CHOOSE_COUNT, kword);
		cfg_close();
		settings_used++;
	endtask

	initial begin : stimulus
		logic [OFFSET_W-1:0] lo;
		logic [OFFSET_W-1:0] hi;
		logic [OFFSET_W-1:0] kword;
		int  size;
		int  k;
		int  max_k;
		int  n_req;
		int  pick;
		int  phase;
		int  directed_total;
		bit  first_restart;
		bit  noisy;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset the block is finished, with or without restart
		send_request(1'b0);
		send_request(1'b1);

		// full walk of a four-value range, two at a time, into exhaustion
		configure(32'd5, 32'd8, 32'd2);
		send_burst(7, 1'b1, 1'b0);

		// top of the value space with the widest combination
		configure(32'hFFFF_FFF8, 32'hFFFF_FFFF, MAX_CHOOSE);
		send_burst(2, 1'b1, 1'b0);

		// whole value space, then move the base without a restart
		configure(32'd0, 32'hFFFF_FFFF, 32'd1);
		send_burst(2, 1'b1, 1'b0);
		drain();
		cfg_write(CFG_RANGE_LOW, 32'h0000_1000);
		cfg_close();
		send_request(1'b0);

		// empty range
		configure(32'hFFFF_FFFF, 32'd0, 32'd1);
		send_request(1'b1);

		// count above the range size
		configure(32'd10, 32'd12, 32'd4);
		send_request(1'b1);

		// counts above the store depth
		configure(32'd0, 32'hFFFF_FFFF, MAX_CHOOSE + 1);
		send_request(1'b1);
		configure(32'd0, 32'hFFFF_FFFF, COUNT_MAX);
		send_request(1'b1);

		// write to an unused index must leave the setting alone
		configure(32'd3, 32'd3, 32'd1);
		cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
		cfg_close();
		send_burst(2, 1'b1, 1'b0);

		directed_total = requests_sent;
		phase = 0;
		while (requests_sent < directed_total + RANDOM_REQUESTS) begin
			pick = $urandom_range(99);
			first_restart = ($urandom_range(9) != 0);
			noisy = ($urandom_range(3) == 0);
			if (pick < 75) begin
				// small range that can be walked to the end
				size = $urandom_range(8);
				lo = ($urandom_range(3) == 0) ? $urandom_range(20) : ($urandom & ~32'hF);
				if (size == 0) begin
					if (lo == 0)
						lo = 32'd1;
					hi = $urandom_range(lo - 1, 0);
				end else begin
					hi = lo + size - 1;
				end
				max_k = (size < MAX_CHOOSE) ? size : MAX_CHOOSE;
				if (size != 0 && $urandom_range(9) != 0)
					k = $urandom_range(max_k, 1);
				else
					k = $urandom_range(COUNT_MAX);
				n_req = n_choose(size, k) + $urandom_range(2, 1);
				if (n_req > 40)
					n_req = 40;
			end else if (pick < 90) begin
				lo = $urandom;
				hi = $urandom;
				k = $urandom_range(COUNT_MAX);
				n_req = $urandom_range(16, 4);
			end else begin
				lo = 32'hFFFF_FFFF - $urandom_range(9);
				hi = 32'hFFFF_FFFF;
				k = $urandom_range(MAX_CHOOSE, 1);
				n_req = n_choose(int'(hi - lo) + 1, k) + $urandom_range(2, 1);
				if (n_req > 40)
					n_req = 40;
			end
			if (phase == 1) begin
				// long run with no idling on either side
				n_req = 40;
			end
			if (phase == 2) begin
				// long output hold-off while requests keep coming
				lo = $urandom_range(32'h7FFF_FFFF);
				hi = 32'hFFFF_FFFF;
				k = MAX_CHOOSE;
				n_req = 16;
				first_restart = 1'b1;
				noisy = 1'b0;
			end
			kword = ($urandom_range(3) == 0) ? (($urandom & ~32'hF) | k) : k;
			configure(lo, hi, kword);
			if ($urandom_range(4) == 0) begin
				cfg_write(CFG_UNUSED, $urandom);
				cfg_close();
			end
			idle_on = (phase != 1);
			if (phase == 2)
				hold_req <= 1'b1;
			send_burst(n_req, first_restart, noisy);
			phase++;
		end
		drain();

		$display("%0d requests over %0d register settings, %0d result beats checked",
			requests_sent, settings_used, beats_checked);
		$display("%0d of those beats reported an exhausted generator", exhaust_reports);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
design/kcg_pkg.sv
design/kcg_offset_file.sv
design/kcg_core.sv
design/k_combination_generator.sv
sim/kcg_checker.sv
sim/k_combination_generator_tb.sv
